### rtl/core/rbpq_pkg.sv
// shared types and codes for the ready/blocked process queue block
// no dependencies; imported by rbpq_cell, rbpq_queue and the top level
`default_nettype none

package rbpq_pkg;

  localparam int PRI_BITS = 4;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_REMOVE  = 2'd2,
    OP_FIND    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  localparam logic QSEL_READY   = 1'b0;
  localparam logic QSEL_BLOCKED = 1'b1;

  // per-cycle command to one row of cells
  typedef struct packed {
    logic ins;     // insert new entry
    logic sorted;  // insert in priority order, else at the tail
    logic del;     // close the gap at the first hit
    logic head;    // hit is the head slot instead of a key match
  } rbpq_ctrl_t;

  // what a row reports back
  typedef struct packed {
    logic hit;
    logic full;
    logic empty;
  } rbpq_qstat_t;

endpackage

`default_nettype wire

### rtl/core/rbpq_cell.sv
// one slot of a queue row: holds a key and a priority, shifts with its neighbors
// depends on rbpq_pkg
`default_nettype none

module rbpq_cell #(
  parameter int KEY_BITS = 32
) (
  input  wire logic                          clk,
  input  wire rbpq_pkg::rbpq_ctrl_t          ctrl,
  input  wire logic                          occ,
  input  wire logic [KEY_BITS-1:0]           new_key,
  input  wire logic [rbpq_pkg::PRI_BITS-1:0] new_pri,
  input  wire logic [KEY_BITS-1:0]           left_key,
  input  wire logic [rbpq_pkg::PRI_BITS-1:0] left_pri,
  input  wire logic [KEY_BITS-1:0]           right_key,
  input  wire logic [rbpq_pkg::PRI_BITS-1:0] right_pri,
  input  wire logic                          keep_in,
  input  wire logic                          hit_in,
  output      logic [KEY_BITS-1:0]           key_o,
  output      logic [rbpq_pkg::PRI_BITS-1:0] pri_o,
  output      logic                          keep_out,
  output      logic                          hit_out,
  output      logic                          first
);
  import rbpq_pkg::*;

  logic [KEY_BITS-1:0] key_r;
  logic [PRI_BITS-1:0] pri_r;
  logic                ge;
  logic                match;

  // entries at or above the new priority stay put; for fifo insert every live one stays
  assign ge       = ctrl.sorted ? (pri_r >= new_pri) : 1'b1;
  assign keep_out = occ & ge;
  assign match    = occ & ~ctrl.head & (key_r == new_key);
  assign hit_out  = hit_in | match;
  assign first    = match & ~hit_in;
  assign key_o    = key_r;
  assign pri_o    = pri_r;

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (!keep_out) begin
        if (keep_in) begin
          key_r <= new_key;
          pri_r <= new_pri;
        end else begin
          key_r <= left_key;
          pri_r <= left_pri;
        end
      end
    end else if (ctrl.del && hit_out) begin
      key_r <= right_key;
      pri_r <= right_pri;
    end
  end

endmodule

`default_nettype wire

### rtl/core/rbpq_queue.sv
// one bounded queue: a row of rbpq_cell slots plus the fill count
// depends on rbpq_pkg and rbpq_cell
`default_nettype none

module rbpq_queue #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 32,
  localparam int CW      = $clog2(DEPTH + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rbpq_pkg::rbpq_ctrl_t          ctrl,
  input  wire logic [KEY_BITS-1:0]           key,
  input  wire logic [rbpq_pkg::PRI_BITS-1:0] pri,
  output      rbpq_pkg::rbpq_qstat_t         stat,
  output      logic [KEY_BITS-1:0]           found_key,
  output      logic [rbpq_pkg::PRI_BITS-1:0] found_pri,
  output      logic [CW-1:0]                 count,
  output      logic [CW-1:0]                 count_nxt
);
  import rbpq_pkg::*;

  logic [CW-1:0]       count_r;
  logic [KEY_BITS-1:0] cell_key  [DEPTH];
  logic [PRI_BITS-1:0] cell_pri  [DEPTH];
  logic [DEPTH-1:0]    occ;
  logic [DEPTH-1:0]    keep;
  logic [DEPTH-1:0]    hit;
  logic [DEPTH-1:0]    first;
  rbpq_ctrl_t          cell_ctrl;
  logic                ins_eff;
  logic                del_eff;

  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);
  // head mode hits slot 0 when there is one; otherwise the chain ends in any match
  assign stat.hit   = ctrl.head ? occ[0] : hit[DEPTH-1];

  assign ins_eff = ctrl.ins & ~stat.full;
  assign del_eff = ctrl.del & stat.hit;

  always_comb begin
    cell_ctrl     = ctrl;
    cell_ctrl.ins = ins_eff;
    cell_ctrl.del = del_eff;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i] = (CW'(i) < count_r);
    rbpq_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .occ       (occ[i]),
      .new_key   (key),
      .new_pri   (pri),
      .left_key  ((i == 0) ? key : cell_key[(i == 0) ? 0 : i-1]),
      .left_pri  ((i == 0) ? pri : cell_pri[(i == 0) ? 0 : i-1]),
      .right_key (cell_key[(i == DEPTH-1) ? i : i+1]),
      .right_pri (cell_pri[(i == DEPTH-1) ? i : i+1]),
      .keep_in   ((i == 0) ? 1'b1 : keep[(i == 0) ? 0 : i-1]),
      .hit_in    ((i == 0) ? ctrl.head : hit[(i == 0) ? 0 : i-1]),
      .key_o     (cell_key[i]),
      .pri_o     (cell_pri[i]),
      .keep_out  (keep[i]),
      .hit_out   (hit[i]),
      .first     (first[i])
    );
  end

  // first match is one-hot, so an and-or picks its data
  always_comb begin
    found_key = '0;
    found_pri = '0;
    if (ctrl.head) begin
      found_key = cell_key[0];
      found_pri = cell_pri[0];
    end else begin
      for (int i = 0; i < DEPTH; i++) begin
        found_key = found_key | (cell_key[i] & {KEY_BITS{first[i]}});
        found_pri = found_pri | (cell_pri[i] & {PRI_BITS{first[i]}});
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ins_eff) begin
      count_nxt = count_r + CW'(1);
    end else if (del_eff) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count = count_r;

endmodule

`default_nettype wire

### rtl/core/ready_blocked_process_queues.sv
// ready_blocked_process_queues: a priority-ordered ready queue and a fifo blocked queue
// of process keys, each a chain of slot cells that all shift at once.
// Input stream in_*: one command per transfer (insert, dequeue head, remove by key,
// find by key). Output stream out_*: one result per command with status, the entry
// touched, and both queue sizes after the command.
// Output: the result is registered at the accept edge and shows on out_* the next
// cycle. Throughput: one command per cycle while out_tready is high; every slot
// compares and shifts at once, and the longest path is the key compare followed by
// the first-match chain through all QUEUE_DEPTH cells.
// Stall: the output register holds its result while out_tready is low; a new command
// is taken when the held result leaves, so while one is held in_tready follows out_tready.
// Reset: both counts go to zero and the output register empties; slot contents are
// left as they are and only read once written.
// Remove and find look through the blocked queue head to tail first, then the ready
// queue; within a queue the match nearest its head wins.
`default_nettype none

module ready_blocked_process_queues #(
  parameter int QUEUE_DEPTH = 16,
  parameter int KEY_BITS    = 32,
  localparam int CW         = $clog2(QUEUE_DEPTH + 1),
  localparam int IN_BITS    = 3 + KEY_BITS + rbpq_pkg::PRI_BITS,
  localparam int IN_W       = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS   = 3 + KEY_BITS + rbpq_pkg::PRI_BITS + 2 * CW,
  localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output      logic             in_tready,
  // opcode, queue_select, name_key, priority_req, zero pad
  input  wire logic [IN_W-1:0]  in_tdata,
  output      logic             out_tvalid,
  input  wire logic             out_tready,
  // status, found_key, found_priority, found_queue, ready_size, blocked_size, zero pad
  output      logic [OUT_W-1:0] out_tdata
);
  import rbpq_pkg::*;

  op_t                 op;
  logic                qsel;
  logic [KEY_BITS-1:0] key;
  logic [PRI_BITS-1:0] pri;
  logic                acc;

  rbpq_ctrl_t          r_ctrl;
  rbpq_ctrl_t          b_ctrl;
  rbpq_qstat_t         r_stat;
  rbpq_qstat_t         b_stat;
  logic [KEY_BITS-1:0] r_key;
  logic [KEY_BITS-1:0] b_key;
  logic [PRI_BITS-1:0] r_pri;
  logic [PRI_BITS-1:0] b_pri;
  logic [CW-1:0]       r_cnt;
  logic [CW-1:0]       b_cnt;
  logic [CW-1:0]       r_cnt_nxt;
  logic [CW-1:0]       b_cnt_nxt;

  status_t             res_status;
  logic [KEY_BITS-1:0] res_key;
  logic [PRI_BITS-1:0] res_pri;
  logic                res_queue;

  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [OUT_W-1:0]    out_data_r;
  logic [OUT_W-1:0]    out_data_nxt;

  assign op   = op_t'(in_tdata[1:0]);
  assign qsel = in_tdata[2];
  assign key  = in_tdata[KEY_BITS+2:3];
  assign pri  = in_tdata[KEY_BITS+PRI_BITS+2:KEY_BITS+3];

  assign in_tready = ~out_valid_r | out_tready;
  assign acc       = in_tvalid & in_tready;

  // a blocked hit shields the ready queue from a remove
  always_comb begin
    b_ctrl.ins    = acc & (op == OP_INSERT) & (qsel == QSEL_BLOCKED);
    b_ctrl.sorted = 1'b0;
    b_ctrl.head   = (op == OP_DEQUEUE);
    b_ctrl.del    = acc & (((op == OP_DEQUEUE) & (qsel == QSEL_BLOCKED))
                           | (op == OP_REMOVE));
    r_ctrl.ins    = acc & (op == OP_INSERT) & (qsel == QSEL_READY);
    r_ctrl.sorted = 1'b1;
    r_ctrl.head   = (op == OP_DEQUEUE);
    r_ctrl.del    = acc & (((op == OP_DEQUEUE) & (qsel == QSEL_READY))
                           | ((op == OP_REMOVE) & ~b_stat.hit));
  end

  rbpq_queue #(
    .DEPTH    (QUEUE_DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_ready (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (r_ctrl),
    .key       (key),
    .pri       (pri),
    .stat      (r_stat),
    .found_key (r_key),
    .found_pri (r_pri),
    .count     (r_cnt),
    .count_nxt (r_cnt_nxt)
  );

  rbpq_queue #(
    .DEPTH    (QUEUE_DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_blocked (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (b_ctrl),
    .key       (key),
    .pri       (pri),
    .stat      (b_stat),
    .found_key (b_key),
    .found_pri (b_pri),
    .count     (b_cnt),
    .count_nxt (b_cnt_nxt)
  );

  always_comb begin
    res_status = ST_OK;
    res_key    = '0;
    res_pri    = '0;
    res_queue  = QSEL_READY;
    case (op)
      OP_INSERT: begin
        res_key   = key;
        res_pri   = pri;
        res_queue = qsel;
        if ((qsel == QSEL_READY) ? r_stat.full : b_stat.full) begin
          res_status = ST_FULL;
        end
      end
      OP_DEQUEUE: begin
        res_queue = qsel;
        if (qsel == QSEL_READY) begin
          if (r_stat.empty) begin
            res_status = ST_EMPTY;
          end else begin
            res_key = r_key;
            res_pri = r_pri;
          end
        end else begin
          if (b_stat.empty) begin
            res_status = ST_EMPTY;
          end else begin
            res_key = b_key;
            res_pri = b_pri;
          end
        end
      end
      OP_REMOVE, OP_FIND: begin
        if (b_stat.hit) begin
          res_key   = b_key;
          res_pri   = b_pri;
          res_queue = QSEL_BLOCKED;
        end else if (r_stat.hit) begin
          res_key   = r_key;
          res_pri   = r_pri;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  assign out_data_nxt = OUT_W'({b_cnt_nxt, r_cnt_nxt, res_queue, res_pri, res_key,
                                res_status});

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (r_cnt <= CW'(QUEUE_DEPTH)) && (b_cnt <= CW'(QUEUE_DEPTH)))
    else $error("queue count above depth");

  a_ready_ins : assert property (@(posedge clk) disable iff (!rst_n)
    acc && (op == OP_INSERT) && (qsel == QSEL_READY) && !r_stat.full
    |=> r_cnt == $past(r_cnt) + CW'(1))
    else $error("ready insert did not grow the ready queue");

  a_blocked_hit_shields : assert property (@(posedge clk) disable iff (!rst_n)
    acc && (op == OP_REMOVE) && b_stat.hit
    |=> (r_cnt == $past(r_cnt)) && (b_cnt == $past(b_cnt) - CW'(1)))
    else $error("remove with blocked hit touched the wrong queue");

  a_find_no_change : assert property (@(posedge clk) disable iff (!rst_n)
    acc && (op == OP_FIND) |=> $stable(r_cnt) && $stable(b_cnt))
    else $error("find changed a queue count");

  a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_tvalid)
    else $error("accepted command left no result");

endmodule

`default_nettype wire
